// ----- hdl/stbs_pkg.sv -----
// Shared types and constants for the sorted-table binary search block.
// Used by the controller, the datapath and the top level; depends on nothing.
package stbs_pkg;

   // Field widths fixed by the interface.
   localparam int DATA_W  = 32;
   localparam int POS_W   = 10;
   localparam int COUNT_W = 11;

   // Default table size.
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   // Operation codes of an input item.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_entry;   // store the request's value in the table
      logic load_search;   // start a search: key, low and high bound
      logic probe;         // read the table at the middle of the range
      logic compare;       // compare the read entry and narrow the range
      logic load_rsp;      // move the search outcome to the result register
   } stbs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_open;    // the search range still holds at least one position
      logic entry_equal;   // the entry read last equals the key
   } stbs_status_type;

endpackage

// ----- hdl/stbs_datapath.sv -----
// Datapath of the sorted-table binary search: table memory, entry count,
// search bounds, compare and result payload. Depends on stbs_pkg.
module stbs_datapath #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [stbs_pkg::COUNT_W-1:0]      csr_wr_data,
   input  logic [stbs_pkg::POS_W-1:0]        req_write_position,
   input  logic signed [stbs_pkg::DATA_W-1:0] req_write_value,
   input  logic signed [stbs_pkg::DATA_W-1:0] req_search_key,
   input  stbs_pkg::stbs_cmd_type            cmd,
   output stbs_pkg::stbs_status_type         status,
   output logic                              rsp_found,
   output logic [stbs_pkg::POS_W-1:0]        rsp_position
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = (stbs_pkg::COUNT_W > $clog2(TABLE_DEPTH + 1)) ?
                       stbs_pkg::COUNT_W : $clog2(TABLE_DEPTH + 1);
   localparam int WA = (AW > stbs_pkg::POS_W) ? AW : stbs_pkg::POS_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic signed [stbs_pkg::DATA_W-1:0] table_mem [TABLE_DEPTH];

   logic [stbs_pkg::COUNT_W-1:0]       count_ff;
   logic [CW-1:0]                      low_ff, low_in;
   logic [CW-1:0]                      high_ff, high_in;   // one past the upper bound
   logic signed [stbs_pkg::DATA_W-1:0] key_ff;
   logic signed [stbs_pkg::DATA_W-1:0] rd_data_ff;
   logic [AW-1:0]                      mid_ff;
   logic                               found_ff;
   logic [AW-1:0]                      hit_ff;
   logic                               rsp_found_ff;
   logic [stbs_pkg::POS_W-1:0]         rsp_position_ff;

   logic [CW-1:0]                      count_ext;
   logic [CW-1:0]                      count_clamped;
   logic [CW:0]                        mid_sum;
   logic [CW-1:0]                      mid;
   logic [CW-1:0]                      mid_ext;
   logic [WA-1:0]                      wr_pos_wide;
   logic [WA-1:0]                      hit_wide;
   logic                               wr_in_range;

   // Entry count is limited to the table depth.
   assign count_ext     = CW'(count_ff);
   assign count_clamped = (count_ext > DEPTH_C) ? DEPTH_C : count_ext;

   // Middle of the range: floor((low + upper) / 2) with upper = high - 1.
   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff} - {{CW{1'b0}}, 1'b1};
   assign mid     = mid_sum[CW:1];
   assign mid_ext = CW'(mid_ff);

   // Writes beyond the table depth are dropped.
   assign wr_pos_wide = WA'(req_write_position);
   assign wr_in_range = CW'(req_write_position) < DEPTH_C;

   assign status.range_open  = low_ff < high_ff;
   assign status.entry_equal = rd_data_ff == key_ff;

   // Next search bounds.
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.load_search) begin
         low_in  = '0;
         high_in = count_clamped;
      end else if (cmd.compare && !status.entry_equal) begin
         if (rd_data_ff < key_ff) begin
            low_in = mid_ext + CW'(1);
         end else begin
            high_in = mid_ext;
         end
      end
   end

   // Entry count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Search bounds.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.write_entry && wr_in_range) begin
         table_mem[wr_pos_wide[AW-1:0]] <= req_write_value;
      end
      if (cmd.probe) begin
         rd_data_ff <= table_mem[mid[AW-1:0]];
         mid_ff     <= mid[AW-1:0];
      end
   end

   // Key and search outcome.
   always_ff @(posedge clock) begin
      if (cmd.load_search) begin
         key_ff   <= req_search_key;
         found_ff <= 1'b0;
         hit_ff   <= '0;
      end else if (cmd.compare && status.entry_equal) begin
         found_ff <= 1'b1;
         hit_ff   <= mid_ff;
      end
   end

   // Result payload register.
   assign hit_wide = WA'(hit_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found_ff    <= found_ff;
         rsp_position_ff <= hit_wide[stbs_pkg::POS_W-1:0];
      end
   end

   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // The lower bound never passes one-past the upper bound.
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      low_ff <= high_ff)
      else $error("search bounds crossed");

   // The range never reaches past the table.
   a_bounds_depth: assert property (@(posedge clock) disable iff (reset)
      high_ff <= DEPTH_C)
      else $error("search range beyond table depth");

   // A probe only happens while the range holds a position.
   a_probe_open: assert property (@(posedge clock) disable iff (reset)
      cmd.probe |-> status.range_open)
      else $error("probe issued on an empty range");

endmodule

// ----- hdl/stbs_ctrl.sv -----
// Controller of the sorted-table binary search: sequences accept, probe,
// compare and result hand-off. Depends on stbs_pkg.
module stbs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_op,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output stbs_pkg::stbs_cmd_type    cmd,
   input  stbs_pkg::stbs_status_type status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_COMPARE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take;
   logic      rsp_free;

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_op == stbs_pkg::OP_SEARCH) begin
                  cmd.load_search = 1'b1;
                  state_in        = S_CHECK;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (status.range_open) begin
               cmd.probe = 1'b1;
               state_in  = S_COMPARE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = status.entry_equal ? S_FINISH : S_CHECK;
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid flag: set on load, cleared once the transfer happens.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A result is only loaded when the output register is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending transfer");

   // An accepted search enters the range check in the next cycle.
   a_search_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_op == stbs_pkg::OP_SEARCH) |=> state_ff == S_CHECK)
      else $error("search did not start");

   // Result valid only rises after a load.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_rsp))
      else $error("result valid without load");

endmodule

// ----- hdl/sorted_table_binary_search.sv -----
// Top level of the sorted-table binary search block.
// Instantiates stbs_ctrl and stbs_datapath; depends on stbs_pkg.
//
//   Port group  Direction  Handshake            Payload
//   req_        in         req_valid/req_stall  op, write_position, write_value, search_key
//   rsp_        out        rsp_valid/rsp_stall  found, position
//   csr_        in         csr_wr_en            entry_count (csr_wr_data)
//
// A write item is taken without leaving the idle state. A search makes P probes
// (at most ceil(log2(count+1)), 11 for 1024 entries), each a registered table
// read followed by a registered compare, with one more range check when the key
// is not found, and ends with the result hand-off.
// Reset clears the entry count, the controller and the result valid; the table
// is not cleared. A stalled result is held while write items keep being taken;
// a finished search waits for the output register before the next item.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [stbs_pkg::COUNT_W-1:0]       csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [stbs_pkg::POS_W-1:0]         req_write_position,
   input  logic signed [stbs_pkg::DATA_W-1:0] req_write_value,
   input  logic signed [stbs_pkg::DATA_W-1:0] req_search_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [stbs_pkg::POS_W-1:0]         rsp_position
);

   stbs_pkg::stbs_cmd_type    cmd;
   stbs_pkg::stbs_status_type status;

   // Sequencing of each item.
   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Table, bounds and result payload.
   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_write_position (req_write_position),
      .req_write_value    (req_write_value),
      .req_search_key     (req_search_key),
      .cmd                (cmd),
      .status             (status),
      .rsp_found          (rsp_found),
      .rsp_position       (rsp_position)
   );

endmodule

// ----- bench/tb_sorted_table_binary_search.sv -----
// Self-checking bench for sorted_table_binary_search: directed rows, then random phases.
// Keeps its own copy of the table and entry count to predict each search outcome that has no given expected result.
// Depends on stbs_pkg and the sorted_table_binary_search top level.
module tb_sorted_table_binary_search;

   localparam int DATA_W          = stbs_pkg::DATA_W;
   localparam int POS_W           = stbs_pkg::POS_W;
   localparam int COUNT_W         = stbs_pkg::COUNT_W;
   localparam int TABLE_DEPTH     = stbs_pkg::DEFAULT_TABLE_DEPTH;
   localparam int SETTLE_CYCLES   = 30;
   localparam int IDLE_LIMIT      = 4000;
   localparam int BURST_CYCLES    = 400;
   localparam int PHASES          = 16;
   localparam int ITEMS_PER_PHASE = 58;

   typedef struct packed {
      logic                     op;
      logic [POS_W-1:0]         write_position;
      logic signed [DATA_W-1:0] write_value;
      logic signed [DATA_W-1:0] search_key;
   } req_item_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } search_result_type;

   typedef enum logic {ROW_ITEM, ROW_SET_COUNT} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      req_item_type       item;
      bit                 typed;
      search_result_type  expected;
      logic [COUNT_W-1:0] count;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [COUNT_W-1:0]       csr_wr_data;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_op;
   logic [POS_W-1:0]         req_write_position;
   logic signed [DATA_W-1:0] req_write_value;
   logic signed [DATA_W-1:0] req_search_key;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_found;
   logic [POS_W-1:0]         rsp_position;

   // Shadow copy of the block's table and entry count.
   bit signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
   bit                     written [TABLE_DEPTH];
   logic [COUNT_W-1:0]     shadow_count;

   search_result_type awaited_results [$];
   stim_row_type      directed [$];
   int             phase_counts [PHASES] = '{1, 2, 3, 5, 8, 16, 33, 64,
                                             1024, 2047, 1025, 0, 7, 100, 1024, 511};
   int             error_count = 0;
   int             sender_gap_pct;
   int             rsp_stall_pct;
   int             burst_requests;
   int             burst_served = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;

   sorted_table_binary_search DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_write_position (req_write_position),
      .req_write_value    (req_write_value),
      .req_search_key     (req_search_key),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_position       (rsp_position)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Bisect the shadow table the way the block does and return the outcome.
   function automatic search_result_type lookup_key(input logic signed [DATA_W-1:0] key);
      search_result_type outcome;
      int low;
      int high;
      int mid;
      outcome = '0;
      low = 0;
      high = ((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count)) - 1;
      while (low <= high) begin
         mid = (low + high) / 2;
         if (shadow_table[mid] == key) begin
            outcome.found = 1'b1;
            outcome.position = POS_W'(mid);
            break;
         end
         if (shadow_table[mid] < key) begin
            low = mid + 1;
         end else begin
            high = mid - 1;
         end
      end
      return outcome;
   endfunction

   // A value inside the band of its position, so banded writes keep the table sorted.
   function automatic logic signed [DATA_W-1:0] band_value(input int pos);
      logic [DATA_W-1:0] bits;
      bits = 32'h8000_0000 + (32'(pos) << 22) + 32'($urandom_range(0, 32'h003F_FFFF));
      return $signed(bits);
   endfunction

   // Mostly searches for keys near the table contents, some banded and noisy writes.
   function automatic req_item_type random_item(input int span);
      req_item_type it;
      int pick;
      it.op = stbs_pkg::OP_SEARCH;
      it.write_position = POS_W'($urandom);
      it.write_value = $signed($urandom);
      it.search_key = $signed($urandom);
      if ($urandom_range(0, 99) < 30) begin
         it.op = stbs_pkg::OP_WRITE;
         if (span > 0 && $urandom_range(0, 1) == 1) begin
            it.write_position = POS_W'($urandom_range(0, span - 1));
         end
         if ($urandom_range(0, 99) < 85) begin
            it.write_value = band_value(int'(it.write_position));
         end
      end else begin
         pick = $urandom_range(0, 99);
         if (span > 0 && pick < 50) begin
            it.search_key = shadow_table[$urandom_range(0, span - 1)];
         end else if (span > 0 && pick < 65) begin
            it.search_key = shadow_table[$urandom_range(0, span - 1)]
                            + (($urandom_range(0, 1) == 1) ? 1 : -1);
         end else if (pick >= 85) begin
            case ($urandom_range(0, 3))
               0: it.search_key = 32'sh8000_0000;
               1: it.search_key = 32'sh7FFF_FFFF;
               2: it.search_key = 32'sh0000_0000;
               default: it.search_key = -32'sd1;
            endcase
         end
      end
      return it;
   endfunction

   function automatic stim_row_type item_row(input logic op, input int pos,
                                             input logic signed [DATA_W-1:0] value,
                                             input logic signed [DATA_W-1:0] key);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.item = '{op, POS_W'(pos), value, key};
      row.typed = 1'b0;
      row.expected = '0;
      row.count = '0;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic signed [DATA_W-1:0] key,
                                                input logic found, input int pos);
      stim_row_type row;
      row = item_row(stbs_pkg::OP_SEARCH, 0, 0, key);
      row.typed = 1'b1;
      row.expected = '{found, POS_W'(pos)};
      return row;
   endfunction

   function automatic stim_row_type count_row(input int count);
      stim_row_type row;
      row = item_row(stbs_pkg::OP_WRITE, 0, 0, 0);
      row.kind = ROW_SET_COUNT;
      row.count = COUNT_W'(count);
      return row;
   endfunction

   // Offer one item, hold it until the transfer happens, then update the shadow state.
   task automatic send_item(input req_item_type it, input bit typed,
                            input search_result_type typed_result);
      if ($urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= it.op;
      req_write_position <= it.write_position;
      req_write_value    <= it.write_value;
      req_search_key     <= it.search_key;
      do @(posedge clock); while (req_stall);
      if (it.op == stbs_pkg::OP_SEARCH) begin
         awaited_results.push_back(typed ? typed_result : lookup_key(it.search_key));
      end else begin
         shadow_table[it.write_position] = it.write_value;
         written[it.write_position] = 1'b1;
      end
   endtask

   // The count register is only written once the block has gone quiet.
   task automatic set_entry_count(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_count = value;
   endtask

   // Write every position below span that was never written, in sorted bands.
   task automatic fill_prefix(input int span);
      req_item_type it;
      for (int p = 0; p < span; p++) begin
         if (!written[p]) begin
            it = random_item(0);
            it.op = stbs_pkg::OP_WRITE;
            it.write_position = POS_W'(p);
            it.write_value = band_value(p);
            send_item(it, 1'b0, '0);
         end
      end
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_gap_pct = sender_pct;
      rsp_stall_pct <= receiver_pct;
   endtask

   // Receiver: random stalls, plus one long hold-off when the sender asks for it.
   always @(posedge clock) begin
      if (burst_left > 0) begin
         rsp_stall  <= 1'b1;
         burst_left <= burst_left - 1;
      end else if (burst_served != burst_requests) begin
         burst_served <= burst_requests;
         burst_left   <= BURST_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // Compare each result transfer with the oldest awaited outcome.
   always @(posedge clock) begin : check_results
      search_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result found=%0d position=%0d",
                     $time, rsp_found, rsp_position);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_found !== want.found) begin
               error_count++;
               $display("%0t: found mismatch, expected %0d, actual %0d",
                        $time, want.found, rsp_found);
            end
            if (rsp_position !== want.position) begin
               error_count++;
               $display("%0t: position mismatch, expected %0d, actual %0d",
                        $time, want.position, rsp_position);
            end
         end
      end
   end

   // Watchdog: too long without any transfer on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int span;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_valid          <= 1'b0;
      req_op             <= stbs_pkg::OP_WRITE;
      req_write_position <= '0;
      req_write_value    <= '0;
      req_search_key     <= '0;
      rsp_stall_pct      <= 0;
      burst_requests     <= 0;
      sender_gap_pct     = 0;
      shadow_count       = '0;

      // Directed rows: empty table, extremes, short counts and an unsorted table.
      directed.push_back(checked_row(0, 1'b0, 0));
      directed.push_back(checked_row(32'sh7FFF_FFFF, 1'b0, 0));
      directed.push_back(item_row(stbs_pkg::OP_WRITE, 0, 32'sh8000_0000, 0));
      directed.push_back(item_row(stbs_pkg::OP_WRITE, 1, -1, 0));
      directed.push_back(item_row(stbs_pkg::OP_WRITE, 2, 0, 0));
      directed.push_back(item_row(stbs_pkg::OP_WRITE, 3, 32'sh7FFF_FFFF, 0));
      directed.push_back(item_row(stbs_pkg::OP_WRITE, 1023, 32'sh7FFF_FFFF, 0));
      directed.push_back(count_row(4));
      directed.push_back(checked_row(32'sh8000_0000, 1'b1, 0));
      directed.push_back(checked_row(-1, 1'b1, 1));
      directed.push_back(checked_row(0, 1'b1, 2));
      directed.push_back(checked_row(32'sh7FFF_FFFF, 1'b1, 3));
      directed.push_back(checked_row(5, 1'b0, 0));
      directed.push_back(checked_row(32'sh8000_0001, 1'b0, 0));
      directed.push_back(count_row(1));
      directed.push_back(checked_row(32'sh8000_0000, 1'b1, 0));
      directed.push_back(checked_row(32'sh7FFF_FFFF, 1'b0, 0));
      directed.push_back(count_row(0));
      directed.push_back(checked_row(-1, 1'b0, 0));
      directed.push_back(count_row(4));
      directed.push_back(item_row(stbs_pkg::OP_WRITE, 1, 100, 0));
      directed.push_back(item_row(stbs_pkg::OP_SEARCH, 0, 0, 0));
      directed.push_back(item_row(stbs_pkg::OP_SEARCH, 0, 0, 100));
      directed.push_back(item_row(stbs_pkg::OP_WRITE, 1, -1, 0));
      directed.push_back(item_row(stbs_pkg::OP_SEARCH, 0, 0, -1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_idling(30, 57);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_SET_COUNT) begin
            set_entry_count(directed[i].count);
         end else begin
            send_item(directed[i].item, directed[i].typed, directed[i].expected);
         end
      end

      // Random phases: set a count, fill the searched prefix, then mixed traffic.
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 5) begin
            set_idling(57, 30);
         end else if (ph == 10) begin
            set_idling(0, 0);
         end
         set_entry_count(COUNT_W'(phase_counts[ph]));
         span = (phase_counts[ph] > TABLE_DEPTH) ? TABLE_DEPTH : phase_counts[ph];
         fill_prefix(span);
         // Hold the receiver off so finished searches back up into the input.
         if (phase_counts[ph] == 2047) begin
            burst_requests <= burst_requests + 1;
         end
         repeat (ITEMS_PER_PHASE) send_item(random_item(span), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
